// File: sv/lec_pkg.sv
// ----------------------------------------------------------------------------
// lec_pkg: shared types and constants of the LMS echo canceller
// Sizes of the filter, fixed-point widths, register indexes, the controller
// state type and the command and status words between controller and datapath.
// ----------------------------------------------------------------------------
package lec_pkg;

    // filter size and coefficient format
    localparam int MAX_TAPS   = 256;
    localparam int COEF_WIDTH = 24;
    localparam int COEF_FRAC  = COEF_WIDTH - 4;
    localparam int IDX_W      = $clog2(MAX_TAPS);
    localparam int TAPS_W     = $clog2(MAX_TAPS + 1);

    // fixed field widths
    localparam int SAMPLE_W   = 16;
    localparam int STEP_W     = 16;
    localparam int TAPS_REG_W = 9;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAPS_IN_USE = 2'd1;
    localparam logic [STEP_W-1:0]     STEP_RESET = 16'd6554;
    localparam logic [TAPS_REG_W-1:0] TAPS_RESET = 9'd256;

    // datapath widths
    localparam int PROD_W    = COEF_WIDTH + SAMPLE_W;
    localparam int ACC_W     = PROD_W + IDX_W;
    localparam int DIFF_W    = ACC_W + 1;
    localparam int MU_W      = STEP_W + SAMPLE_W + 2;
    localparam int UPD_SHIFT = 45 - COEF_FRAC;
    localparam int UPD_W     = MU_W + SAMPLE_W;
    localparam int DELTA_W   = UPD_W + 1 - UPD_SHIFT;
    localparam int SUM_W     = DELTA_W + 1;

    // controller states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MAC,
        S_MAC_WAIT,
        S_ERR_SUB,
        S_ERR_CLAMP,
        S_MU_MUL,
        S_OUT,
        S_UPD,
        S_UPD_WAIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic              clear;
        logic              load;
        logic              mac_issue;
        logic              upd_issue;
        logic              err_sub;
        logic              err_clamp;
        logic              mu_mul;
        logic              out_load;
        logic [IDX_W-1:0]  tap;
        logic [STEP_W-1:0] step_size;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } t_sts;

endpackage

// File: sv/lms_echo_canceller_unit.sv
// An input word is taken only in idle, so the next word waits until the single
// MAC pass and the single update pass of the last one are done, each pass one
// tap a cycle over the taps in use through one port of the coefficient and
// history memories.
// Reset (synchronous, active low) and a taps_in_use write start a clearing
// pass of both memories; no input word is taken until it ends.
// ----------------------------------------------------------------------------
// lms_echo_canceller_unit: LMS adaptive FIR echo canceller
// Stream in loudspeaker and microphone samples, stream out the cleaned
// sample; configuration through a separate write channel.
// ----------------------------------------------------------------------------
module lms_echo_canceller_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // slave side
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [2*lec_pkg::SAMPLE_W-1:0]      s_axis_tdata,  // [15:0] feedback_sample,
                                                               // [31:16] mic_sample
    // master side
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [lec_pkg::SAMPLE_W-1:0]        m_axis_tdata,  // [15:0] cleaned_sample
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [lec_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [lec_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import lec_pkg::*;

    t_cmd                       w_cmd;
    t_sts                       w_sts;
    logic signed [SAMPLE_W-1:0] w_feedback;
    logic signed [SAMPLE_W-1:0] w_mic;
    logic signed [SAMPLE_W-1:0] w_out_sample;

    // unpack the input word
    assign w_feedback   = signed'(s_axis_tdata[SAMPLE_W-1:0]);
    assign w_mic        = signed'(s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W]);
    assign m_axis_tdata = w_out_sample;
    assign o_cfg_ready  = 1'b1;

    lec_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    lec_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_feedback   (w_feedback),
        .i_mic        (w_mic),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_sample (w_out_sample)
    );

endmodule

// File: sv/lec_ctrl.sv
// ----------------------------------------------------------------------------
// lec_ctrl: sequencer of the LMS echo canceller
// Holds the configuration registers, runs the clearing pass, the MAC pass,
// the error steps and the coefficient update pass, and issues commands.
// ----------------------------------------------------------------------------
module lec_ctrl (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_cfg_valid,
    input  logic [lec_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lec_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  lec_pkg::t_sts                    i_sts,
    output lec_pkg::t_cmd                    o_cmd
);
    import lec_pkg::*;

    t_state                r_state, n_state;
    logic [TAPS_W-1:0]     r_cnt, n_cnt;
    logic [STEP_W-1:0]     r_step;
    logic [TAPS_REG_W-1:0] r_taps;
    logic [TAPS_W-1:0]     w_active;
    logic                  w_last;
    logic                  w_taps_wr;

    // number of taps actually run: zero acts as one, clip at the maximum
    always_comb begin
        if (r_taps == '0) begin
            w_active = TAPS_W'(1);
        end else if (32'(r_taps) > 32'(MAX_TAPS)) begin
            w_active = TAPS_W'(MAX_TAPS);
        end else begin
            w_active = TAPS_W'(r_taps);
        end
    end

    assign w_last    = (r_cnt == w_active - TAPS_W'(1));
    assign w_taps_wr = i_cfg_valid && (i_cfg_index == REG_TAPS_IN_USE);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_RESET;
            r_taps <= TAPS_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_STEP_SIZE:   r_step <= i_cfg_data[STEP_W-1:0];
                REG_TAPS_IN_USE: r_taps <= i_cfg_data[TAPS_REG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // state and tap counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_CLEAR: begin
                if (r_cnt == TAPS_W'(MAX_TAPS - 1)) begin
                    n_state = S_IDLE;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + TAPS_W'(1);
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_MAC;
                    n_cnt   = '0;
                end
            end
            S_MAC: begin
                if (w_last) begin
                    n_state = S_MAC_WAIT;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + TAPS_W'(1);
                end
            end
            S_MAC_WAIT: begin
                if (!i_sts.pipe_busy) begin
                    n_state = S_ERR_SUB;
                end
            end
            S_ERR_SUB:   n_state = S_ERR_CLAMP;
            S_ERR_CLAMP: n_state = S_MU_MUL;
            S_MU_MUL:    n_state = S_OUT;
            S_OUT: begin
                if (i_sts.out_free) begin
                    n_state = S_UPD;
                    n_cnt   = '0;
                end
            end
            S_UPD: begin
                if (w_last) begin
                    n_state = S_UPD_WAIT;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + TAPS_W'(1);
                end
            end
            S_UPD_WAIT: begin
                if (!i_sts.pipe_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
                n_cnt   = '0;
            end
        endcase
        // a change of tap count restarts the clearing pass
        if (w_taps_wr) begin
            n_state = S_CLEAR;
            n_cnt   = '0;
        end
    end

    // commands; hold off the input word while a tap count write lands
    always_comb begin
        o_cmd           = '0;
        o_cmd.tap       = r_cnt[IDX_W-1:0];
        o_cmd.step_size = r_step;
        o_in_ready      = 1'b0;
        case (r_state)
            S_CLEAR:     o_cmd.clear = 1'b1;
            S_IDLE: begin
                o_in_ready = !w_taps_wr;
                o_cmd.load = i_in_valid && !w_taps_wr;
            end
            S_MAC:       o_cmd.mac_issue = 1'b1;
            S_ERR_SUB:   o_cmd.err_sub   = 1'b1;
            S_ERR_CLAMP: o_cmd.err_clamp = 1'b1;
            S_MU_MUL:    o_cmd.mu_mul    = 1'b1;
            S_OUT:       o_cmd.out_load  = i_sts.out_free;
            S_UPD:       o_cmd.upd_issue = 1'b1;
            default: begin
            end
        endcase
    end

`ifndef SYNTHESIS
    a_tap_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC || r_state == S_UPD) |-> (r_cnt < w_active))
        else $error("tap counter beyond active taps");

    a_acc_settled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ERR_SUB) |-> !i_sts.pipe_busy)
        else $error("error formed before MAC pipeline emptied");

    a_taps_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_taps_wr |=> (r_state == S_CLEAR && r_cnt == '0))
        else $error("tap count write did not restart clearing");

    a_clear_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR && r_cnt == TAPS_W'(MAX_TAPS - 1) && !w_taps_wr)
            |=> (r_state == S_IDLE && !i_sts.pipe_busy))
        else $error("clearing pass did not end in idle");
`endif

endmodule

// File: sv/lec_datapath.sv
// ----------------------------------------------------------------------------
// lec_datapath: memories and arithmetic of the LMS echo canceller
// History and coefficient memories, MAC pipeline, error rounding and clamp,
// step-times-error product, coefficient update pipeline and output register.
// ----------------------------------------------------------------------------
module lec_datapath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  lec_pkg::t_cmd                        i_cmd,
    output lec_pkg::t_sts                        o_sts,
    input  logic signed [lec_pkg::SAMPLE_W-1:0]  i_feedback,
    input  logic signed [lec_pkg::SAMPLE_W-1:0]  i_mic,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [lec_pkg::SAMPLE_W-1:0]  o_out_sample
);
    import lec_pkg::*;

    localparam logic signed [DIFF_W-1:0]  ERR_HALF = DIFF_W'(1) <<< (COEF_FRAC - 1);
    localparam logic signed [DIFF_W-1:0]  E_MAX    = DIFF_W'(32767);
    localparam logic signed [DIFF_W-1:0]  E_MIN    = -E_MAX;
    localparam logic signed [UPD_W:0]     UPD_HALF = (UPD_W + 1)'(1) <<< (UPD_SHIFT - 1);
    localparam logic signed [SUM_W-1:0]   W_MAX    =
        SUM_W'((64'sd1 <<< (COEF_WIDTH - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0]   W_MIN    = -W_MAX - SUM_W'(1);

    // memories
    logic signed [COEF_WIDTH-1:0] coef_mem [MAX_TAPS];
    logic signed [SAMPLE_W-1:0]   hist_mem [MAX_TAPS];

    logic [IDX_W-1:0]             r_newest, n_newest;
    logic [IDX_W-1:0]             w_slot;
    logic signed [SAMPLE_W-1:0]   r_mic;
    logic signed [COEF_WIDTH-1:0] r_coef_q;
    logic signed [SAMPLE_W-1:0]   r_hist_q;

    // pipeline control
    logic                         r_v1, r_v2, r_upd1, r_upd2;
    logic [IDX_W-1:0]             r_addr1, r_addr2;

    // arithmetic
    logic signed [PROD_W-1:0]     r_prod;
    logic signed [ACC_W-1:0]      r_acc;
    logic signed [DIFF_W-1:0]     r_diff;
    logic signed [DIFF_W-1:0]     w_err_full;
    logic signed [SAMPLE_W-1:0]   r_err;
    logic signed [STEP_W:0]       w_step_s;
    logic signed [STEP_W+SAMPLE_W:0] w_mu_prod;
    logic signed [MU_W-1:0]       r_mu_e;
    logic signed [UPD_W-1:0]      r_upd_prod;
    logic signed [COEF_WIDTH-1:0] r_coef2;
    logic signed [UPD_W:0]        w_delta_sum;
    logic signed [DELTA_W-1:0]    w_delta;
    logic signed [SUM_W-1:0]      w_sum;
    logic signed [COEF_WIDTH-1:0] w_coef_new;

    logic                         r_out_valid;
    logic signed [SAMPLE_W-1:0]   r_out;

    // advance the newest slot with wrap
    assign n_newest = (r_newest == IDX_W'(MAX_TAPS - 1)) ? '0 : r_newest + IDX_W'(1);

    // history slot of tap k: newest minus k, modulo the line length
    always_comb begin
        if (r_newest >= i_cmd.tap) begin
            w_slot = r_newest - i_cmd.tap;
        end else begin
            w_slot = IDX_W'(MAX_TAPS - 32'(i_cmd.tap) + 32'(r_newest));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_newest <= '0;
        end else if (i_cmd.clear) begin
            r_newest <= '0;
        end else if (i_cmd.load) begin
            r_newest <= n_newest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mic <= i_mic;
        end
    end

    // history memory: clear, push new sample, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            hist_mem[i_cmd.tap] <= '0;
        end else if (i_cmd.load) begin
            hist_mem[n_newest] <= i_feedback;
        end
        r_hist_q <= hist_mem[w_slot];
    end

    // coefficient memory: clear, write back updates, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            coef_mem[i_cmd.tap] <= '0;
        end else if (r_v2 && r_upd2) begin
            coef_mem[r_addr2] <= w_coef_new;
        end
        r_coef_q <= coef_mem[i_cmd.tap];
    end

    // pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_upd1 <= 1'b0;
            r_upd2 <= 1'b0;
        end else begin
            r_v1   <= i_cmd.mac_issue || i_cmd.upd_issue;
            r_v2   <= r_v1;
            r_upd1 <= i_cmd.upd_issue;
            r_upd2 <= r_upd1;
        end
    end

    // multiply stage for both passes
    always_ff @(posedge i_clk) begin
        r_addr1    <= i_cmd.tap;
        r_addr2    <= r_addr1;
        r_prod     <= r_coef_q * r_hist_q;
        r_upd_prod <= r_mu_e * r_hist_q;
        r_coef2    <= r_coef_q;
    end

    // accumulate the echo estimate
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_acc <= '0;
        end else if (r_v2 && !r_upd2) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // error: round half up to Q15, clamp to plus or minus full scale
    assign w_err_full = r_diff >>> COEF_FRAC;
    assign w_step_s   = signed'({1'b0, i_cmd.step_size});
    assign w_mu_prod  = w_step_s * r_err;

    always_ff @(posedge i_clk) begin
        if (i_cmd.err_sub) begin
            r_diff <= (DIFF_W'(r_mic) <<< COEF_FRAC) - DIFF_W'(r_acc) + ERR_HALF;
        end
        if (i_cmd.err_clamp) begin
            if (w_err_full > E_MAX) begin
                r_err <= SAMPLE_W'(E_MAX);
            end else if (w_err_full < E_MIN) begin
                r_err <= SAMPLE_W'(E_MIN);
            end else begin
                r_err <= SAMPLE_W'(w_err_full);
            end
        end
        if (i_cmd.mu_mul) begin
            r_mu_e <= MU_W'(w_mu_prod) <<< 1;
        end
    end

    // coefficient update: round the step term, add, saturate
    assign w_delta_sum = (UPD_W + 1)'(r_upd_prod) + UPD_HALF;
    assign w_delta     = DELTA_W'(w_delta_sum >>> UPD_SHIFT);
    assign w_sum       = SUM_W'(r_coef2) + SUM_W'(w_delta);

    always_comb begin
        if (w_sum > W_MAX) begin
            w_coef_new = COEF_WIDTH'(W_MAX);
        end else if (w_sum < W_MIN) begin
            w_coef_new = COEF_WIDTH'(W_MIN);
        end else begin
            w_coef_new = COEF_WIDTH'(w_sum);
        end
    end

    // output register: hold the word until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= r_err;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_sample    = r_out;
    assign o_sts.pipe_busy = r_v1 || r_v2;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

endmodule

// File: tb/lms_echo_canceller_unit_tb.sv
// ----------------------------------------------------------------------------
// lms_echo_canceller_unit_tb: self-checking bench of the LMS echo canceller
// Streams loudspeaker and microphone sample pairs through the block with
// random gaps and stalls on both sides. An in-bench predictor of the adaptive
// filter works out each cleaned sample in acceptance order. The bench steps
// through several register settings, each written once all results are back.
// ----------------------------------------------------------------------------
module lms_echo_canceller_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import lec_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam int          LONG_HOLD   = 3000;
    localparam int          SETTLE      = 2 * MAX_TAPS + 20;
    localparam longint      COEF_TOP    = (longint'(1) << (COEF_WIDTH - 1)) - 1;
    localparam longint      COEF_BOTTOM = -COEF_TOP - 1;
    localparam longint      CLEAN_TOP   = 32767;

    // indexes that select no register
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    // one input word: feedback in the low half, microphone in the high half
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] mic;
        logic signed [SAMPLE_W-1:0] feedback;
    } t_sample_pair;

    logic                        i_clk;
    logic                        i_rst_n        = 1'b0;
    logic                        s_axis_tvalid  = 1'b0;
    logic                        s_axis_tready;
    logic [2*SAMPLE_W-1:0]       s_axis_tdata   = '0;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready  = 1'b0;
    logic [SAMPLE_W-1:0]         m_axis_tdata;
    logic                        i_cfg_valid    = 1'b0;
    logic                        o_cfg_ready;
    logic [CFG_IDX_W-1:0]        i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0]       i_cfg_data     = '0;

    // queues between stimulus, driver and checker
    t_sample_pair                sample_pairs_pending[$];
    logic signed [SAMPLE_W-1:0]  cleaned_expected[$];

    // handshake flags seen at the last rising edge
    logic                        in_word_taken  = 1'b0;
    logic                        cfg_word_taken = 1'b0;

    // idling control
    bit                          src_gaps_on    = 1'b1;
    bit                          sink_gaps_on   = 1'b1;
    int                          src_gap_left   = 0;
    int                          sink_hold_left = 0;
    int                          hold_asked     = 0;
    int                          hold_seen      = 0;

    int                          fail_count     = 0;
    int unsigned                 cycle_count    = 0;
    logic signed [SAMPLE_W-1:0]  cleaned_want;

    // predictor state
    longint                      coef_mem[MAX_TAPS];
    logic signed [SAMPLE_W-1:0]  ref_line[MAX_TAPS];
    int                          ref_newest;
    longint                      step_mu;
    int                          taps_reg;

    lms_echo_canceller_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // gap length: mostly none or short, now and then long
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 20);
        end
        return $urandom_range(40, 150);
    endfunction

    // clear coefficients, history and the write pointer
    function automatic void clear_filter();
        for (int k = 0; k < MAX_TAPS; k++) begin
            coef_mem[k] = 0;
            ref_line[k] = '0;
        end
        ref_newest = 0;
    endfunction

    function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                           logic [CFG_DATA_W-1:0] value);
        if (idx == REG_STEP_SIZE) begin
            step_mu = longint'(value[STEP_W-1:0]);
        end else if (idx == REG_TAPS_IN_USE) begin
            taps_reg = int'(value[TAPS_REG_W-1:0]);
            clear_filter();
        end
    endfunction

    // one LMS step: push the reference, estimate the echo, emit the error, adapt
    function automatic logic signed [SAMPLE_W-1:0] cancel_echo(
            logic signed [SAMPLE_W-1:0] x, logic signed [SAMPLE_W-1:0] d);
        int     n_taps;
        int     slot;
        longint acc;
        longint err;
        longint mu_e;
        longint prod;
        longint delta;
        longint w;
        n_taps = (taps_reg == 0) ? 1 : ((taps_reg > MAX_TAPS) ? MAX_TAPS : taps_reg);
        ref_newest = (ref_newest + 1) % MAX_TAPS;
        ref_line[ref_newest] = x;

        // echo estimate, exact at the coefficient scale times Q15
        acc  = 0;
        slot = ref_newest;
        for (int k = 0; k < n_taps; k++) begin
            acc += coef_mem[k] * longint'(ref_line[slot]);
            slot = (slot == 0) ? MAX_TAPS - 1 : slot - 1;
        end

        // round half up to Q15, then clamp symmetrically
        err = longint'(d) * (longint'(1) << COEF_FRAC) - acc;
        err = (err + (longint'(1) << (COEF_FRAC - 1))) >>> COEF_FRAC;
        if (err > CLEAN_TOP) begin
            err = CLEAN_TOP;
        end
        if (err < -CLEAN_TOP) begin
            err = -CLEAN_TOP;
        end

        // adapt every tap in use with the clamped error
        mu_e = step_mu * err * 2;
        slot = ref_newest;
        for (int k = 0; k < n_taps; k++) begin
            prod  = mu_e * longint'(ref_line[slot]);
            delta = (prod + (longint'(1) << (UPD_SHIFT - 1))) >>> UPD_SHIFT;
            w     = coef_mem[k] + delta;
            if (w > COEF_TOP) begin
                w = COEF_TOP;
            end
            if (w < COEF_BOTTOM) begin
                w = COEF_BOTTOM;
            end
            coef_mem[k] = w;
            slot = (slot == 0) ? MAX_TAPS - 1 : slot - 1;
        end
        return err[SAMPLE_W-1:0];
    endfunction

    // sender: hold a word until taken, then idle or offer the next one
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !in_word_taken) begin
            s_axis_tvalid <= 1'b1;
        end else if (src_gap_left > 0) begin
            src_gap_left--;
            s_axis_tvalid <= 1'b0;
        end else if (sample_pairs_pending.size() > 0) begin
            s_axis_tdata  <= sample_pairs_pending.pop_front();
            s_axis_tvalid <= 1'b1;
            src_gap_left  = src_gaps_on ? draw_gap() : 0;
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // receiver: random stalls, plus a long hold-off when asked
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_seen != hold_asked) begin
            hold_seen      = hold_asked;
            sink_hold_left = LONG_HOLD;
            m_axis_tready <= 1'b0;
        end else if (sink_hold_left > 0) begin
            sink_hold_left--;
            m_axis_tready <= 1'b0;
        end else if (!sink_gaps_on) begin
            m_axis_tready <= 1'b1;
        end else begin
            sink_hold_left = draw_gap();
            m_axis_tready <= (sink_hold_left == 0);
        end
    end

    // monitor: check results, predict accepted words, track register writes
    always @(posedge i_clk) begin
        in_word_taken  <= i_rst_n && s_axis_tvalid && s_axis_tready;
        cfg_word_taken <= i_rst_n && i_cfg_valid && o_cfg_ready;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (cleaned_expected.size() == 0) begin
                    $error("cleaned_sample: unexpected word, expected none, actual %0d",
                           $signed(m_axis_tdata));
                    fail_count++;
                end else begin
                    cleaned_want = cleaned_expected.pop_front();
                    if (m_axis_tdata !== cleaned_want) begin
                        $error("cleaned_sample: expected %0d, actual %0d",
                               cleaned_want, $signed(m_axis_tdata));
                        fail_count++;
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                apply_register(i_cfg_index, i_cfg_data);
            end
            if (s_axis_tvalid && s_axis_tready) begin
                cleaned_expected.push_back(cancel_echo(s_axis_tdata[SAMPLE_W-1:0],
                                                       s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W]));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(negedge i_clk); while (!cfg_word_taken);
        i_cfg_valid <= 1'b0;
    endtask

    // wait until every word is sent and every result has come back
    task automatic wait_quiet();
        do @(negedge i_clk);
        while (sample_pairs_pending.size() != 0 || s_axis_tvalid ||
               cleaned_expected.size() != 0);
    endtask

    task automatic push_pair(int x, int d);
        t_sample_pair p;
        p.feedback = x[SAMPLE_W-1:0];
        p.mic      = d[SAMPLE_W-1:0];
        sample_pairs_pending.push_back(p);
    endtask

    // mostly an attenuated echo of the last reference plus noise, else wild values
    task automatic queue_random_pairs(int count);
        int x;
        int d;
        int last_x;
        last_x = 0;
        repeat (count) begin
            case ($urandom_range(0, 9))
                0:       x = $urandom_range(0, 1) ? 32767 : -32768;
                1, 2, 3: x = int'($urandom_range(0, 2000)) - 1000;
                default: x = int'($urandom_range(0, 65535)) - 32768;
            endcase
            case ($urandom_range(0, 19))
                0, 1, 2:       d = $urandom_range(0, 1) ? 32767 : -32768;
                3, 4, 5, 6, 7: d = int'($urandom_range(0, 65535)) - 32768;
                default: begin
                    d = (last_x >>> 1) + int'($urandom_range(0, 128)) - 64;
                    d = (d > 32767) ? 32767 : ((d < -32768) ? -32768 : d);
                end
            endcase
            push_pair(x, d);
            last_x = x;
        end
    endtask

    task automatic run_random(int count, bit gaps);
        src_gaps_on  = gaps;
        sink_gaps_on = gaps;
        queue_random_pairs(count);
        wait_quiet();
    endtask

    // stimulus
    initial begin
        step_mu  = longint'(STEP_RESET);
        taps_reg = int'(TAPS_RESET);
        clear_filter();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: full scale corners, minus full scale error
        push_pair(0, 0);
        push_pair(32767, 32767);
        push_pair(-32768, -32768);
        push_pair(32767, -32768);
        push_pair(-32768, 32767);
        push_pair(-1, 1);
        wait_quiet();

        // largest step, taps zero acting as one: saturate and clamp high
        write_reg(REG_STEP_SIZE, 16'hFFFF);
        write_reg(REG_TAPS_IN_USE, 16'd0);
        push_pair(32767, 32767);
        push_pair(32767, 32767);
        push_pair(32767, -32768);
        push_pair(-32768, 32767);
        push_pair(1, -1);
        push_pair(0, -32768);
        wait_quiet();

        // taps above maximum, no adaptation
        write_reg(REG_TAPS_IN_USE, 16'd511);
        write_reg(REG_STEP_SIZE, 16'd0);
        push_pair(12345, -23456);
        push_pair(-32768, -32768);
        push_pair(32767, 0);
        wait_quiet();

        // step size change keeps the filter state
        write_reg(REG_STEP_SIZE, 16'hFFFF);
        push_pair(-32768, 32767);
        push_pair(-32768, 32767);
        push_pair(32767, -32768);
        push_pair(-32768, 32767);
        wait_quiet();

        // random phases over several settings
        write_reg(REG_STEP_SIZE, 16'd6554);
        write_reg(REG_TAPS_IN_USE, 16'd8);
        run_random(110, 1'b1);

        write_reg(REG_TAPS_IN_USE, 16'd0);
        run_random(40, 1'b0);

        write_reg(REG_STEP_SIZE, 16'd0);
        write_reg(REG_TAPS_IN_USE, 16'd1);
        run_random(30, 1'b1);

        // long receiver hold-off so the block fills and stalls its input
        write_reg(REG_STEP_SIZE, 16'd1000);
        write_reg(REG_TAPS_IN_USE, 16'd32);
        src_gaps_on  = 1'b0;
        sink_gaps_on = 1'b1;
        queue_random_pairs(80);
        hold_asked++;
        wait_quiet();

        write_reg(REG_STEP_SIZE, 16'd20000);
        write_reg(REG_TAPS_IN_USE, 16'h01FF);
        run_random(25, 1'b1);

        write_reg(REG_STEP_SIZE, 16'd300);
        write_reg(REG_TAPS_IN_USE, 16'd256);
        run_random(25, 1'b0);

        write_reg(REG_STEP_SIZE, 16'h8000);
        write_reg(REG_TAPS_IN_USE, 16'd3);
        run_random(100, 1'b1);

        // spare indexes are ignored, high data bits of the taps word dropped
        write_reg(REG_SPARE_A, 16'(($urandom)));
        write_reg(REG_SPARE_B, 16'hFFFF);
        write_reg(REG_TAPS_IN_USE, 16'hFE05);
        write_reg(REG_STEP_SIZE, 16'(($urandom_range(1, 65535))));
        run_random(90, 1'b1);

        // let any stray word show up
        repeat (SETTLE) @(posedge i_clk);
        if (cleaned_expected.size() != 0) begin
            $error("cleaned_sample: %0d expected words never arrived",
                   cleaned_expected.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
